// File: rtl/rtph_pkg.sv
// Shared types, constants and codes for the RTP header parser.
// No dependencies; used by every module under rtl.
package rtph_pkg;

    localparam int unsigned PAYLOAD_TYPE_W  = 7;
    localparam int unsigned MAX_PAYLOAD_W   = 14;
    localparam int unsigned CFG_DATA_W      = 14;
    localparam int unsigned CFG_INDEX_W     = 1;
    localparam int unsigned OFFSET_W        = 14;
    localparam int unsigned REASON_W        = 3;
    // Wide enough for the largest header: 12 + 15*4 + 4 + 65535*4
    localparam int unsigned VERDICT_W       = 19;

    localparam int unsigned DEF_MAX_PACKET_BYTES = 8192;

    localparam logic [PAYLOAD_TYPE_W-1:0] PAYLOAD_TYPE_RESET = 7'd111;
    localparam logic [MAX_PAYLOAD_W-1:0]  MAX_PAYLOAD_RESET  = 14'd4000;

    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_TYPE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD  = 1'd1;

    localparam logic [REASON_W-1:0] REASON_OK        = 3'd0;
    localparam logic [REASON_W-1:0] REASON_SHORT     = 3'd1;
    localparam logic [REASON_W-1:0] REASON_VERSION   = 3'd2;
    localparam logic [REASON_W-1:0] REASON_CSRC      = 3'd3;
    localparam logic [REASON_W-1:0] REASON_EXTENSION = 3'd4;
    localparam logic [REASON_W-1:0] REASON_PADDING   = 3'd5;
    localparam logic [REASON_W-1:0] REASON_SIZE      = 3'd6;
    localparam logic [REASON_W-1:0] REASON_TOO_LONG  = 3'd7;

    localparam logic [1:0] RTP_VERSION = 2'd2;
    localparam int unsigned FIXED_HDR_BYTES = 12;

    typedef struct packed {
        logic [7:0]  first_header_byte;
        logic        type_matches;
        logic [15:0] seq;
        logic [31:0] time_stamp;
        logic [31:0] source;
        logic [15:0] ext_words;
    } hdr_fields_t;

    typedef struct packed {
        logic                accepted;
        logic [REASON_W-1:0] reason;
        logic [31:0]         ssrc;
        logic [15:0]         seq;
        logic [31:0]         time_stamp;
        logic [OFFSET_W-1:0] offset;
        logic [OFFSET_W-1:0] length;
    } verdict_t;

endpackage

// File: rtl/rtp_header_parser.sv
// RTP header parser top level: configuration registers, input and result registers.
// Depends on rtph_pkg, rtph_capture and rtph_verdict.
//
// Takes an RTP packet one byte per transfer, last_byte marking the final byte,
// and gives one result transfer per packet: accepted with SSRC, sequence number,
// timestamp, payload offset and payload length, or a drop reason with those
// fields zero. A new byte is taken every cycle unless the input stalls; each byte
// passes from the input register through the header capture and, on the final
// byte, the checks into the result register, where the result is held and
// offered. The input stalls only while a final byte waits for an earlier result
// that is still held. Packets longer than MAX_PACKET_BYTES are
// counted to saturation and dropped as too long. Write payload_type (index 0)
// and max_payload (index 1) only between packets with no result outstanding.
module rtp_header_parser #(
    parameter int unsigned MAX_PACKET_BYTES = rtph_pkg::DEF_MAX_PACKET_BYTES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         data_byte,
    input  logic                               last_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               accepted,
    output logic [rtph_pkg::REASON_W-1:0]      drop_reason,
    output logic [31:0]                        ssrc,
    output logic [15:0]                        sequence_res,
    output logic [31:0]                        timestamp,
    output logic [rtph_pkg::OFFSET_W-1:0]      payload_offset,
    output logic [rtph_pkg::OFFSET_W-1:0]      payload_length,
    input  logic                               cfg_write,
    input  logic [rtph_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rtph_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rtph_pkg::*;

    localparam int unsigned CW = $clog2(MAX_PACKET_BYTES + 2);

    logic [PAYLOAD_TYPE_W-1:0] payload_type_reg;
    logic [MAX_PAYLOAD_W-1:0]  max_payload_reg;
    logic                      in_valid_reg;
    logic [7:0]                byte_reg;
    logic                      last_reg;
    logic                      out_valid_reg;
    verdict_t                  result_reg;
    logic                      advance;
    logic                      in_take;
    hdr_fields_t               fields_next;
    logic [CW-1:0]             count_next;
    verdict_t                  verdict;

    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_type_reg <= PAYLOAD_TYPE_RESET;
            max_payload_reg  <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PAYLOAD_TYPE: payload_type_reg <= cfg_data[PAYLOAD_TYPE_W-1:0];
                CFG_MAX_PAYLOAD:  max_payload_reg  <= cfg_data[MAX_PAYLOAD_W-1:0];
                default:          max_payload_reg  <= max_payload_reg;
            endcase
        end
    end

    // Hold the input byte until the capture stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    rtph_capture #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .CW               (CW)
    ) u_capture (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .data_byte    (byte_reg),
        .last_byte    (last_reg),
        .payload_type (payload_type_reg),
        .fields_next  (fields_next),
        .count_next   (count_next)
    );

    rtph_verdict #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .CW               (CW)
    ) u_verdict (
        .fields      (fields_next),
        .count       (count_next),
        .pad         (byte_reg),
        .max_payload (max_payload_reg),
        .verdict     (verdict)
    );

    // Hold the verdict until the downstream transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            result_reg <= verdict;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = result_reg.accepted;
    assign drop_reason    = result_reg.reason;
    assign ssrc           = result_reg.ssrc;
    assign sequence_res   = result_reg.seq;
    assign timestamp      = result_reg.time_stamp;
    assign payload_offset = result_reg.offset;
    assign payload_length = result_reg.length;

endmodule

// File: rtl/rtph_capture.sv
// Per-packet header capture: byte counter and fixed/extension header fields.
// Depends on rtph_pkg.
module rtph_capture #(
    parameter int unsigned MAX_PACKET_BYTES = rtph_pkg::DEF_MAX_PACKET_BYTES,
    parameter int unsigned CW = $clog2(MAX_PACKET_BYTES + 2)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  step,
    input  logic [7:0]                            data_byte,
    input  logic                                  last_byte,
    input  logic [rtph_pkg::PAYLOAD_TYPE_W-1:0]   payload_type,
    output rtph_pkg::hdr_fields_t                 fields_next,
    output logic [CW-1:0]                         count_next
);
    import rtph_pkg::*;

    hdr_fields_t           fields_reg;
    logic [CW-1:0]         count_reg;
    logic [VERDICT_W-1:0]  hdr_base;
    logic                  ext_hi;
    logic                  ext_lo;

    always_comb
    begin
        hdr_base = VERDICT_W'(FIXED_HDR_BYTES)
                 + {{(VERDICT_W-6){1'b0}}, fields_reg.first_header_byte[3:0], 2'b00};
        ext_hi = (count_reg >= CW'(2)) && fields_reg.first_header_byte[4]
               && (VERDICT_W'(count_reg) == hdr_base + VERDICT_W'(2));
        ext_lo = (count_reg >= CW'(2)) && fields_reg.first_header_byte[4]
               && (VERDICT_W'(count_reg) == hdr_base + VERDICT_W'(3));

        fields_next = fields_reg;
        if (count_reg == CW'(0))
        begin
            fields_next.first_header_byte = data_byte;
        end
        else if (count_reg == CW'(1))
        begin
            fields_next.type_matches = (data_byte[6:0] == payload_type);
        end
        else if (count_reg < CW'(4))
        begin
            fields_next.seq = {fields_reg.seq[7:0], data_byte};
        end
        else if (count_reg < CW'(8))
        begin
            fields_next.time_stamp = {fields_reg.time_stamp[23:0], data_byte};
        end
        else if (count_reg < CW'(12))
        begin
            fields_next.source = {fields_reg.source[23:0], data_byte};
        end

        if (ext_hi)
        begin
            fields_next.ext_words = {data_byte, fields_reg.ext_words[7:0]};
        end
        else if (ext_lo)
        begin
            fields_next.ext_words = {fields_reg.ext_words[15:8], data_byte};
        end

        if (count_reg < CW'(MAX_PACKET_BYTES + 1))
        begin
            count_next = count_reg + CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fields_reg <= '0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                fields_reg <= '0;
                count_reg  <= '0;
            end
            else
            begin
                fields_reg <= fields_next;
                count_reg  <= count_next;
            end
        end
    end

endmodule

// File: rtl/rtph_verdict.sv
// End-of-packet checks: drop reason, payload offset and payload length.
// Depends on rtph_pkg.
module rtph_verdict #(
    parameter int unsigned MAX_PACKET_BYTES = rtph_pkg::DEF_MAX_PACKET_BYTES,
    parameter int unsigned CW = $clog2(MAX_PACKET_BYTES + 2)
) (
    input  rtph_pkg::hdr_fields_t                fields,
    input  logic [CW-1:0]                        count,
    input  logic [7:0]                           pad,
    input  logic [rtph_pkg::MAX_PAYLOAD_W-1:0]   max_payload,
    output rtph_pkg::verdict_t                   verdict
);
    import rtph_pkg::*;

    logic [VERDICT_W-1:0] len;
    logic [VERDICT_W-1:0] hdr_base;
    logic [VERDICT_W-1:0] hdr_ext;
    logic [VERDICT_W-1:0] hdr;
    logic [VERDICT_W-1:0] size;
    logic [VERDICT_W-1:0] size_net;
    logic [VERDICT_W-1:0] pad_w;
    logic                 has_ext;
    logic                 has_pad;
    logic [REASON_W-1:0]  reason;

    always_comb
    begin
        len      = VERDICT_W'(count);
        pad_w    = VERDICT_W'(pad);
        has_ext  = fields.first_header_byte[4];
        has_pad  = fields.first_header_byte[5];
        hdr_base = VERDICT_W'(FIXED_HDR_BYTES)
                 + {{(VERDICT_W-6){1'b0}}, fields.first_header_byte[3:0], 2'b00};
        hdr_ext  = hdr_base + VERDICT_W'(4) + {1'b0, fields.ext_words, 2'b00};
        hdr      = has_ext ? hdr_ext : hdr_base;
        size     = len - hdr;
        size_net = has_pad ? size - pad_w : size;

        if (len > VERDICT_W'(MAX_PACKET_BYTES))
        begin
            reason = REASON_TOO_LONG;
        end
        else if (len < VERDICT_W'(FIXED_HDR_BYTES))
        begin
            reason = REASON_SHORT;
        end
        else if (fields.first_header_byte[7:6] != RTP_VERSION || !fields.type_matches)
        begin
            reason = REASON_VERSION;
        end
        else if (len < hdr_base)
        begin
            reason = REASON_CSRC;
        end
        else if (has_ext && (len < hdr_base + VERDICT_W'(4) || len < hdr_ext))
        begin
            reason = REASON_EXTENSION;
        end
        else if (has_pad && (size == '0 || pad_w == '0 || pad_w > size))
        begin
            reason = REASON_PADDING;
        end
        else if (size_net == '0 || size_net > VERDICT_W'(max_payload))
        begin
            reason = REASON_SIZE;
        end
        else
        begin
            reason = REASON_OK;
        end

        verdict.accepted   = (reason == REASON_OK);
        verdict.reason     = reason;
        verdict.ssrc       = verdict.accepted ? fields.source : '0;
        verdict.seq        = verdict.accepted ? fields.seq : '0;
        verdict.time_stamp = verdict.accepted ? fields.time_stamp : '0;
        verdict.offset     = verdict.accepted ? hdr[OFFSET_W-1:0] : '0;
        verdict.length     = verdict.accepted ? size_net[OFFSET_W-1:0] : '0;
    end

endmodule
